// ----- sv/pfba_pkg.sv -----
// Shared types and constants of the page frame bitmap allocator.
// Command, status and config index codes, controller states and the control/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package pfba_pkg;

  localparam int CFG_REGIONS = 3;
  localparam int PFN_W       = 32;
  localparam int CNT_W       = 17;
  localparam int WORD_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int RSV_SHIFT   = 15;
  localparam int RSV_W       = 3;

  localparam logic [WORD_W-1:0] FULL_WORD = '1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NO_MEM     = 2'd1,
    STS_RANGE      = 2'd2,
    STS_BAD_REGION = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_BASE0  = 3'd0,
    CFG_BASE1  = 3'd1,
    CFG_BASE2  = 3'd2,
    CFG_PAGES0 = 3'd3,
    CFG_PAGES1 = 3'd4,
    CFG_PAGES2 = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_INIT_CLR,
    S_INIT_RSV,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_WR,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    clr_wr;
    logic    res_load;
    status_e res_code;
    logic    idx_zero;
    logic    idx_start;
    logic    idx_inc;
    logic    pass_clr;
    logic    pass_set;
    logic    init_clr_wr;
    logic    init_rsv_wr;
    logic    alloc_rd;
    logic    alloc_commit;
    logic    free_rd;
    logic    free_commit;
    logic    out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    cmd_e cmd;
    logic bad_region;
    logic free_zero;
    logic idx_at_end;
    logic pass2;
    logic word_full;
    logic sweep_last;
    logic oob;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/pfba_ctrl.sv -----
// Controller state machine of the page frame bitmap allocator.
// Sequences reset clearing, init sweep, alloc word scan and free; uses pfba_pkg.
`timescale 1ns / 1ps

module pfba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pfba_pkg::dp_stat_t stat_i,
  output pfba_pkg::dp_cmd_t  ctrl_o
);
  import pfba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.bad_region) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.cmd)
            CMD_ALLOC: state_d = stat_i.free_zero ? S_DONE : S_ALLOC_RD;
            CMD_FREE:  state_d = stat_i.oob ? S_DONE : S_FREE_WR;
            CMD_INIT:  state_d = S_INIT_CLR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_INIT_CLR: begin
        if (stat_i.sweep_last) state_d = S_INIT_RSV;
      end
      S_INIT_RSV: state_d = S_DONE;
      S_ALLOC_RD: begin
        if (stat_i.idx_at_end) begin
          if (stat_i.pass2) state_d = S_DONE;
        end else begin
          state_d = S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: state_d = stat_i.word_full ? S_ALLOC_RD : S_DONE;
      S_FREE_WR:   state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.res_code = STS_OK;
    in_stall_o      = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: ctrl_o.clr_wr = 1'b1;
      S_IDLE:  ctrl_o.accept = in_valid_i;
      S_DECODE: begin
        ctrl_o.res_load = 1'b1;
        if (stat_i.bad_region) begin
          ctrl_o.res_code = STS_BAD_REGION;
        end else begin
          case (stat_i.cmd)
            CMD_ALLOC: begin
              if (stat_i.free_zero) begin
                ctrl_o.res_code = STS_NO_MEM;
              end else begin
                ctrl_o.idx_start = 1'b1;
                ctrl_o.pass_clr  = 1'b1;
              end
            end
            CMD_FREE: begin
              if (stat_i.oob) begin
                ctrl_o.res_code = STS_RANGE;
              end else begin
                ctrl_o.free_rd = 1'b1;
              end
            end
            CMD_INIT: ctrl_o.idx_zero = 1'b1;
            default:  ctrl_o.res_code = STS_OK;
          endcase
        end
      end
      S_INIT_CLR: begin
        ctrl_o.init_clr_wr = 1'b1;
        ctrl_o.idx_inc     = 1'b1;
      end
      S_INIT_RSV: ctrl_o.init_rsv_wr = 1'b1;
      S_ALLOC_RD: begin
        if (stat_i.idx_at_end) begin
          if (stat_i.pass2) begin
            ctrl_o.res_load = 1'b1;
            ctrl_o.res_code = STS_NO_MEM;
          end else begin
            ctrl_o.idx_zero = 1'b1;
            ctrl_o.pass_set = 1'b1;
          end
        end else begin
          ctrl_o.alloc_rd = 1'b1;
        end
      end
      S_ALLOC_CHK: begin
        if (stat_i.word_full) begin
          ctrl_o.idx_inc = 1'b1;
        end else begin
          ctrl_o.alloc_commit = 1'b1;
        end
      end
      S_FREE_WR: ctrl_o.free_commit = 1'b1;
      S_DONE:    ctrl_o.out_load = stat_i.out_free;
      default:   ctrl_o.res_code = STS_OK;
    endcase
  end

endmodule

// ----- sv/pfba_datapath.sv -----
// Datapath of the page frame bitmap allocator: config registers, bitmap memory,
// per-region free counts and cursors, scan index and result register; uses pfba_pkg.
`timescale 1ns / 1ps

module pfba_datapath #(
  parameter int NUM_REGIONS      = 3,
  parameter int PAGES_PER_REGION = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        cmd_i,
  input  logic [1:0]                        region_i,
  input  logic [pfba_pkg::PFN_W-1:0]        page_number_i,
  input  logic                              cfg_valid_i,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfba_pkg::PFN_W-1:0]        cfg_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [pfba_pkg::PFN_W-1:0]        alloc_pfn_o,
  output logic [1:0]                        status_o,
  output logic [pfba_pkg::CNT_W-1:0]        free_left_o,
  input  pfba_pkg::dp_cmd_t                 ctrl_i,
  output pfba_pkg::dp_stat_t                stat_o
);
  import pfba_pkg::*;

  localparam int EFF       = (NUM_REGIONS < CFG_REGIONS) ? NUM_REGIONS : CFG_REGIONS;
  localparam int CAP_MAX   = (2 ** CNT_W) - 1;
  localparam int CAP       = (PAGES_PER_REGION > CAP_MAX) ? CAP_MAX : PAGES_PER_REGION;
  localparam int WORDS     = (CAP + WORD_W - 1) / WORD_W;
  localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RG_W      = (EFF > 1) ? $clog2(EFF) : 1;
  localparam int MEM_DEPTH = EFF * (2 ** WA);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [CNT_W-1:0]  PAGE_CAP = CNT_W'(CAP);
  localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);
  localparam logic [CNT_W:0]    RSV_ROUND = (CNT_W + 1)'((2 ** RSV_SHIFT) - 1);

  function automatic logic [MEM_AW-1:0] mk_addr(input logic [1:0] r, input logic [WA-1:0] w);
    mk_addr = MEM_AW'({r, w});
  endfunction

  // latched item
  cmd_e             cmd_q;
  logic [1:0]       region_q;
  logic [PFN_W-1:0] pfn_q;

  // configuration
  logic [PFN_W-1:0] base_q  [CFG_REGIONS];
  logic [CNT_W-1:0] pcfg_q  [CFG_REGIONS];

  // per-region state
  logic [CNT_W-1:0] free_q  [EFF];
  logic [WA-1:0]    cursor_q[EFF];

  // scan / sweep
  logic [WA:0]       idx_q;
  logic              pass_q;
  logic [MEM_AW-1:0] clr_q;

  // bitmap memory
  logic [WORD_W-1:0] mem_q [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              we, re;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;

  // result
  logic [PFN_W-1:0] res_pfn_q;
  status_e          res_sts_q;
  logic             out_valid_q;
  logic [PFN_W-1:0] out_pfn_q;
  status_e          out_sts_q;
  logic [CNT_W-1:0] out_free_q;

  // decode of the current item
  logic [1:0]        csel;
  logic              bad;
  logic [RG_W-1:0]   rg;
  logic [PFN_W-1:0]  base;
  logic [CNT_W-1:0]  pages;
  logic [WA:0]       words;
  logic [WA:0]       start;
  logic [PFN_W:0]    lim;
  logic              oob;
  logic [PFN_W-1:0]  off;
  logic [WA-1:0]     free_word;
  logic [WORD_W-1:0] free_mask;
  logic              bit_set;
  logic [CNT_W:0]    rsv_sum;
  logic [RSV_W-1:0]  reserve;
  logic [WORD_W-1:0] rsv_word;
  logic [4:0]        zbit;
  logic [WORD_W-1:0] alloc_word;
  logic [PFN_W-1:0]  alloc_pfn;

  always_comb begin
    csel      = (region_q == 2'd3) ? 2'd0 : region_q;
    bad       = ({1'b0, region_q} >= 3'(EFF));
    rg        = bad ? '0 : RG_W'(region_q);
    base      = base_q[csel];
    pages     = (pcfg_q[csel] > PAGE_CAP) ? PAGE_CAP : pcfg_q[csel];
    words     = (WA + 1)'(pages >> 5);
    start     = ({1'b0, cursor_q[rg]} < words) ? {1'b0, cursor_q[rg]} : words;
    // free range: base < pfn < base + pages, sum without wrap
    lim       = {1'b0, base} + (PFN_W + 1)'(pages);
    oob       = (pfn_q <= base) || ({1'b0, pfn_q} >= lim);
    off       = pfn_q - base;
    free_word = WA'(off[CNT_W-1:0] >> 5);
    free_mask = WORD_W'(1) << off[4:0];
    bit_set   = |(rdata_q & free_mask);
    // leading pages reserved for the bitmap: ceil(pages / 32768)
    rsv_sum   = {1'b0, pages} + RSV_ROUND;
    reserve   = RSV_W'(rsv_sum >> RSV_SHIFT);
    rsv_word  = (WORD_W'(1) << reserve) - WORD_W'(1);
  end

  // lowest clear bit of the word just read
  always_comb begin
    zbit = 5'd31;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!rdata_q[i]) zbit = 5'(i);
    end
    alloc_word = rdata_q | (WORD_W'(1) << zbit);
    alloc_pfn  = base + PFN_W'({idx_q[WA-1:0], zbit});
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (ctrl_i.clr_wr) begin
      we = 1'b1;
    end else if (ctrl_i.init_clr_wr) begin
      we    = 1'b1;
      waddr = mk_addr(region_q, idx_q[WA-1:0]);
    end else if (ctrl_i.init_rsv_wr) begin
      we    = 1'b1;
      waddr = mk_addr(region_q, '0);
      wdata = rsv_word;
    end else if (ctrl_i.alloc_commit) begin
      we    = 1'b1;
      waddr = mk_addr(region_q, idx_q[WA-1:0]);
      wdata = alloc_word;
    end else if (ctrl_i.free_commit && bit_set) begin
      we    = 1'b1;
      waddr = mk_addr(region_q, free_word);
      wdata = rdata_q & ~free_mask;
    end
    re    = ctrl_i.alloc_rd || ctrl_i.free_rd;
    raddr = ctrl_i.alloc_rd ? mk_addr(region_q, idx_q[WA-1:0])
                            : mk_addr(region_q, free_word);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // latched item, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q    <= cmd_e'(cmd_i);
      region_q <= region_i;
      pfn_q    <= page_number_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_REGIONS; i++) begin
        base_q[i] <= '0;
        pcfg_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BASE0:  base_q[0] <= cfg_data_i;
        CFG_BASE1:  base_q[1] <= cfg_data_i;
        CFG_BASE2:  base_q[2] <= cfg_data_i;
        CFG_PAGES0: pcfg_q[0] <= cfg_data_i[CNT_W-1:0];
        CFG_PAGES1: pcfg_q[1] <= cfg_data_i[CNT_W-1:0];
        CFG_PAGES2: pcfg_q[2] <= cfg_data_i[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // per-region counters, scan control and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EFF; i++) begin
        free_q[i]   <= '0;
        cursor_q[i] <= '0;
      end
      idx_q     <= '0;
      pass_q    <= 1'b0;
      clr_q     <= '0;
      res_pfn_q <= '0;
      res_sts_q <= STS_OK;
    end else begin
      if (ctrl_i.clr_wr) clr_q <= clr_q + MEM_AW'(1);

      if (ctrl_i.idx_zero) begin
        idx_q <= '0;
      end else if (ctrl_i.idx_start) begin
        idx_q <= start;
      end else if (ctrl_i.idx_inc) begin
        idx_q <= idx_q + (WA + 1)'(1);
      end

      if (ctrl_i.pass_clr) begin
        pass_q <= 1'b0;
      end else if (ctrl_i.pass_set) begin
        pass_q <= 1'b1;
      end

      if (ctrl_i.init_rsv_wr) begin
        free_q[rg]   <= pages - CNT_W'(reserve);
        cursor_q[rg] <= '0;
      end else if (ctrl_i.alloc_commit) begin
        free_q[rg]   <= free_q[rg] - CNT_W'(1);
        cursor_q[rg] <= idx_q[WA-1:0];
      end else if (ctrl_i.free_commit && bit_set) begin
        free_q[rg]   <= free_q[rg] + CNT_W'(1);
      end

      if (ctrl_i.res_load) begin
        res_sts_q <= ctrl_i.res_code;
        res_pfn_q <= '0;
      end else if (ctrl_i.alloc_commit) begin
        res_pfn_q <= alloc_pfn;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_pfn_q  <= res_pfn_q;
      out_sts_q  <= res_sts_q;
      out_free_q <= bad ? '0 : free_q[rg];
    end
  end

  assign out_valid_o = out_valid_q;
  assign alloc_pfn_o = out_pfn_q;
  assign status_o    = out_sts_q;
  assign free_left_o = out_free_q;

  always_comb begin
    stat_o            = '0;
    stat_o.clr_done   = (clr_q == MEM_LAST);
    stat_o.cmd        = cmd_q;
    stat_o.bad_region = bad;
    stat_o.free_zero  = (free_q[rg] == '0);
    stat_o.idx_at_end = (idx_q == words);
    stat_o.pass2      = pass_q;
    stat_o.word_full  = (rdata_q == FULL_WORD);
    stat_o.sweep_last = &idx_q[WA-1:0];
    stat_o.oob        = oob;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  a_alloc_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.alloc_commit |-> (free_q[rg] != '0) && !bad)
    else $error("alloc commit with zero free count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.alloc_rd |-> (idx_q < words))
    else $error("scan read past the region's word count");

  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.free_commit |-> !oob && !bad)
    else $error("free commit of a page outside the region");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a pending transfer");

endmodule

// ----- sv/page_frame_bitmap_allocator_unit.sv -----
// Top level of the page frame bitmap allocator.
// Joins pfba_ctrl (sequencer) and pfba_datapath (bitmap memory, counters); uses pfba_pkg.
//
//  channel  dir  handshake                  payload
//  -------  ---  -------------------------  ---------------------------------------
//  in       in   in_valid_i / in_stall_o    cmd_i, region_i, page_number_i
//  out      out  out_valid_o / out_stall_i  alloc_pfn_o, status_o, free_left_o
//  cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item at a time; a transfer on "in" is taken only while the sequencer is idle.
// Steps per item: bad region, no-op, out-of-range free or zero free count go from
// decode to done; free reads the word, then clears its bit; alloc reads bitmap words
// from the region's cursor, one read per word through the single memory read port,
// wraps once to word 0, and ends with no memory when both passes come up empty;
// init clears one region's 2^WA padded words (2048 by default), sets reserve bits.
// After reset the bitmap memory is cleared one word per cycle, all of NUM_REGIONS'
// effective count times 2^WA words (6144 by default); "in" stalls meanwhile,
// configuration writes are taken as ever (cfg_ready_o is always high).
// A finished result waits in the output register; the next item is accepted
// while it is stalled.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_unit #(
  parameter int NUM_REGIONS      = 3,
  parameter int PAGES_PER_REGION = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [1:0]                     region_i,
  input  logic [pfba_pkg::PFN_W-1:0]     page_number_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pfba_pkg::PFN_W-1:0]     alloc_pfn_o,
  output logic [1:0]                     status_o,
  output logic [pfba_pkg::CNT_W-1:0]     free_left_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pfba_pkg::PFN_W-1:0]     cfg_data_i
);
  import pfba_pkg::*;

  dp_cmd_t  ctrl;
  dp_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  pfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pfba_datapath #(
    .NUM_REGIONS      (NUM_REGIONS),
    .PAGES_PER_REGION (PAGES_PER_REGION)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .region_i      (region_i),
    .page_number_i (page_number_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .alloc_pfn_o   (alloc_pfn_o),
    .status_o      (status_o),
    .free_left_o   (free_left_o),
    .ctrl_i        (ctrl),
    .stat_o        (stat)
  );

endmodule
